// File: rtl/mfw_pkg.sv
// Shared types and constants for the multi-channel frame watchdog.
// Holds the channel record layout, request codes and sequencer states.
// Depends on nothing; the core, mfw_ram and mfw_eval use it.
`default_nettype none

package mfw_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [15:0] PERIOD_RESET = 16'd10;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_REGISTER = 3'd0;
  localparam logic [2:0] REQ_FRAME    = 3'd1;
  localparam logic [2:0] REQ_START    = 3'd2;
  localparam logic [2:0] REQ_STOP     = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;

  // Configuration register indexes.
  localparam logic REG_CHECK_PERIOD = 1'b0;

  // One channel record as held in the record memory.
  typedef struct packed {
    logic [15:0] threshold;
    logic [31:0] frame_count;
    logic [31:0] seen_count;
    logic [31:0] change_time;
  } rec_t;

  typedef enum logic [1:0] {
    MODE_FRAME,
    MODE_START,
    MODE_TICK
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Control handed to the record evaluator.
  typedef struct packed {
    mode_t       mode;
    logic        chan_valid;
    logic [31:0] now_time;
  } eval_ctl_t;

  typedef struct packed {
    rec_t rec;
    logic expire;
  } eval_res_t;

endpackage

`default_nettype wire

// File: rtl/mfw_req_if.sv
// Request channel of the frame watchdog: valid/ready plus the request beat.
// Depends on nothing.
`default_nettype none

interface mfw_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  channel;
  logic [15:0] threshold_ms;

  modport source (output valid, req_type, channel, threshold_ms, input ready);
  modport sink   (input valid, req_type, channel, threshold_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/mfw_rsp_if.sv
// Result channel of the frame watchdog: valid/ready plus the result beat.
// Depends on nothing.
`default_nettype none

interface mfw_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] expired_mask;

  modport source (output valid, ok, expired_mask, input ready);
  modport sink   (input valid, ok, expired_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/multi_channel_frame_watchdog_core.sv
// Multi-channel frame watchdog core.
// Requests arrive as beats on the req channel (valid/ready) and each one
// yields exactly one result beat on the rsp channel. A register request
// arms a channel with its threshold, a frame request bumps the channel's
// frame counter, start and stop switch checking on and off, and a tick
// runs the stall check over every channel and advances the time base by
// the check period, which is written through the APB port at address 0.
// Register, stop, unknown and refused requests go from the idle state
// straight to the done state; an accepted frame passes through the frame
// state first, and an accepted start or tick sweeps the record memory at
// one channel per cycle. The sweep speed is set by the single read and write
// port of the record memory; the read of the next channel overlaps the
// write-back of the current one. One request is in flight at a time.
// A finished result sits in the output register; while the receiver stalls
// the core still accepts and works on the next request, which then waits
// in the done state until the output register frees up.
// Reset (synchronous) clears the valid bits of all channels, the time base
// and the run flag and restores the check period to 10. The record memory
// is not cleared: a register request writes the whole record.
// Depends on mfw_pkg, mfw_req_if, mfw_rsp_if, mfw_ram and mfw_eval.
`default_nettype none

module multi_channel_frame_watchdog_core #(
  parameter int NUM_CHANNELS = mfw_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mfw_req_if.sink          req,
  mfw_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Control state.
  mfw_pkg::state_t        state, state_next;
  mfw_pkg::mode_t         mode, mode_next;
  logic                   running, running_next;
  logic [31:0]            now_time, now_time_next;
  logic [NUM_CHANNELS-1:0] chan_valid, chan_valid_next;
  logic [15:0]            check_period;
  logic [CW:0]            idx, idx_next;
  logic [CW-1:0]          pend_idx, pend_idx_next;
  logic                   res_ok, res_ok_next;
  logic [7:0]             mask, mask_next;
  logic                   out_valid, out_valid_next;
  logic                   out_ok, out_ok_next;
  logic [7:0]             out_mask, out_mask_next;

  // Memory port signals.
  logic                   mem_we;
  logic [CW-1:0]          mem_waddr;
  mfw_pkg::rec_t          mem_wdata;
  logic [CW-1:0]          mem_raddr;
  mfw_pkg::rec_t          mem_rdata;

  mfw_pkg::eval_ctl_t     ev_ctl;
  mfw_pkg::eval_res_t     ev_res;

  logic [CW-1:0]          ch_addr;
  logic                   ch_in_range;
  logic                   cfg_write;

  // APB side: the only register is the check period.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == mfw_pkg::REG_CHECK_PERIOD) ? {16'd0, check_period} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_period <= mfw_pkg::PERIOD_RESET;
    end else if (cfg_write && (paddr[2] == mfw_pkg::REG_CHECK_PERIOD)) begin
      check_period <= pwdata[15:0];
    end
  end

  mfw_ram #(
    .DEPTH (NUM_CHANNELS),
    .AW    (CW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The evaluator always works on the record read for pend_idx.
  assign ev_ctl.mode       = mode;
  assign ev_ctl.chan_valid = chan_valid[pend_idx];
  assign ev_ctl.now_time   = now_time;

  mfw_eval u_eval (
    .ctl    (ev_ctl),
    .rec_in (mem_rdata),
    .res    (ev_res)
  );

  assign ch_addr     = CW'(req.channel);
  assign ch_in_range = (int'(req.channel) < NUM_CHANNELS);

  assign req.ready = (state == mfw_pkg::ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.ok           = out_ok;
  assign rsp.expired_mask = out_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mfw_pkg::ST_IDLE;
      running    <= 1'b0;
      now_time   <= 32'd0;
      chan_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      running    <= running_next;
      now_time   <= now_time_next;
      chan_valid <= chan_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode     <= mode_next;
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    res_ok   <= res_ok_next;
    mask     <= mask_next;
    out_ok   <= out_ok_next;
    out_mask <= out_mask_next;
  end

  // Sequencer. Writes to the record memory happen only in the idle state
  // (register requests) and in the frame and sweep states, and every request
  // passes through the done state before the next one is accepted, so a read
  // never meets a pending write to the same entry. Within a sweep the read and
  // the write-back address different channels.
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    running_next    = running;
    now_time_next   = now_time;
    chan_valid_next = chan_valid;
    idx_next        = idx;
    pend_idx_next   = pend_idx;
    res_ok_next     = res_ok;
    mask_next       = mask;
    out_valid_next  = out_valid && !rsp.ready;
    out_ok_next     = out_ok;
    out_mask_next   = out_mask;
    mem_we          = 1'b0;
    mem_waddr       = pend_idx;
    mem_wdata       = ev_res.rec;
    mem_raddr       = idx[CW-1:0];

    case (state)
      mfw_pkg::ST_IDLE: begin
        if (req.valid) begin
          mask_next   = 8'd0;
          res_ok_next = 1'b0;
          state_next  = mfw_pkg::ST_DONE;
          case (req.req_type)
            mfw_pkg::REQ_REGISTER: begin
              if (ch_in_range && !chan_valid[ch_addr] && (req.threshold_ms > check_period)) begin
                mem_we                  = 1'b1;
                mem_waddr               = ch_addr;
                mem_wdata.threshold     = req.threshold_ms;
                mem_wdata.frame_count   = 32'd0;
                mem_wdata.seen_count    = 32'd0;
                mem_wdata.change_time   = now_time;
                chan_valid_next[ch_addr] = 1'b1;
                res_ok_next             = 1'b1;
              end
            end
            mfw_pkg::REQ_FRAME: begin
              if (ch_in_range && chan_valid[ch_addr]) begin
                mem_raddr     = ch_addr;
                pend_idx_next = ch_addr;
                mode_next     = mfw_pkg::MODE_FRAME;
                state_next    = mfw_pkg::ST_FRAME;
              end
            end
            mfw_pkg::REQ_START: begin
              if (!running) begin
                mem_raddr     = '0;
                pend_idx_next = '0;
                idx_next      = (CW+1)'(1);
                mode_next     = mfw_pkg::MODE_START;
                state_next    = mfw_pkg::ST_SWEEP;
              end
            end
            mfw_pkg::REQ_STOP: begin
              res_ok_next  = running;
              running_next = 1'b0;
            end
            mfw_pkg::REQ_TICK: begin
              if (running) begin
                mem_raddr     = '0;
                pend_idx_next = '0;
                idx_next      = (CW+1)'(1);
                mode_next     = mfw_pkg::MODE_TICK;
                state_next    = mfw_pkg::ST_SWEEP;
              end
            end
            default: begin
              res_ok_next = 1'b0;
            end
          endcase
        end
      end

      mfw_pkg::ST_FRAME: begin
        mem_we      = 1'b1;
        res_ok_next = 1'b1;
        state_next  = mfw_pkg::ST_DONE;
      end

      mfw_pkg::ST_SWEEP: begin
        // Write back the channel whose record just arrived and fetch the next.
        mem_we = 1'b1;
        for (int b = 0; b < 8; b++) begin
          if (ev_res.expire && (int'(pend_idx) == b)) begin
            mask_next[b] = 1'b1;
          end
        end
        if (int'(idx) < NUM_CHANNELS) begin
          mem_raddr     = idx[CW-1:0];
          pend_idx_next = idx[CW-1:0];
          idx_next      = idx + (CW+1)'(1);
        end else begin
          res_ok_next = 1'b1;
          state_next  = mfw_pkg::ST_DONE;
          if (mode == mfw_pkg::MODE_START) begin
            running_next = 1'b1;
          end else begin
            now_time_next = now_time + {16'd0, check_period};
          end
        end
      end

      mfw_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_ok_next    = res_ok;
          out_mask_next  = mask;
          state_next     = mfw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mfw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mfw_ram.sv
// Channel record memory: one write port, one read port, registered read data.
// Depends on mfw_pkg for the record type.
`default_nettype none

module mfw_ram #(
  parameter int DEPTH = mfw_pkg::NUM_CHANNELS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  mfw_pkg::rec_t      wdata,
  input  wire logic [AW-1:0] raddr,
  output mfw_pkg::rec_t      rdata
);

  mfw_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mfw_eval.sv
// Read-modify-write datapath for one channel record: frame count increment,
// start re-arm and the periodic stall check. Depends on mfw_pkg.
`default_nettype none

module mfw_eval (
  input  mfw_pkg::eval_ctl_t ctl,
  input  mfw_pkg::rec_t      rec_in,
  output mfw_pkg::eval_res_t res
);

  logic [31:0] elapsed;

  assign elapsed = ctl.now_time - rec_in.change_time;

  always_comb begin
    res.rec    = rec_in;
    res.expire = 1'b0;
    case (ctl.mode)
      mfw_pkg::MODE_FRAME: begin
        res.rec.frame_count = rec_in.frame_count + 32'd1;
      end
      mfw_pkg::MODE_START: begin
        res.rec.change_time = ctl.now_time;
      end
      mfw_pkg::MODE_TICK: begin
        if (ctl.chan_valid && (rec_in.frame_count != 32'd0)) begin
          if (rec_in.frame_count == rec_in.seen_count) begin
            res.expire = (elapsed > {16'd0, rec_in.threshold});
          end else begin
            res.rec.seen_count  = rec_in.frame_count;
            res.rec.change_time = ctl.now_time;
          end
        end
      end
      default: begin
        res.rec = rec_in;
      end
    endcase
  end

endmodule

`default_nettype wire
